/* rtl/core/chct_pkg.sv */
`default_nettype none
package chct_pkg;

  localparam int unsigned CODE_W    = 16;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned SYM_W     = 8;
  localparam int unsigned SYM_COUNT = 256;
  localparam int unsigned ENTRY_W   = LEN_W + CODE_W;

  typedef enum logic [1:0] {
    REQ_NEW_TABLE  = 2'd0,
    REQ_LOAD_COUNT = 2'd1,
    REQ_ADD_SYMBOL = 2'd2,
    REQ_LOOKUP     = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_NO_SLOT   = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_LOOKUP = 1'b1
  } state_t;

  // Command from the front end to the code generator, valid for one cycle.
  typedef struct packed {
    logic               clear;
    logic               load;
    logic               add;
    logic [LEN_W-1:0]   length_index;
    logic [COUNT_W-1:0] count;
  } gen_cmd_t;

  // Outcome of an append, combinational on the current state.
  typedef struct packed {
    logic              ok;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  length;
  } gen_rsp_t;

endpackage
`default_nettype wire

/* rtl/core/chct_ram.sv */
`default_nettype none
module chct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/chct_codegen.sv */
`default_nettype none
module chct_codegen #(
  parameter int unsigned MAX_SYMBOLS     = 256,
  parameter int unsigned MAX_CODE_LENGTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire chct_pkg::gen_cmd_t cmd,
  output chct_pkg::gen_rsp_t      rsp
);

  localparam int unsigned LI_W = $clog2(MAX_CODE_LENGTH);
  localparam int unsigned SL_W = $clog2(MAX_SYMBOLS + 1);

  logic [chct_pkg::COUNT_W-1:0] counts_r [MAX_CODE_LENGTH];
  logic [chct_pkg::CODE_W-1:0]  next_code_r, next_code_nxt;
  logic [chct_pkg::LEN_W-1:0]   cur_len_r, cur_len_nxt;
  logic [chct_pkg::COUNT_W-1:0] left_r, left_nxt;
  logic [SL_W-1:0]              loaded_r, loaded_nxt;

  logic [MAX_CODE_LENGTH-1:0]   nz;
  logic [MAX_CODE_LENGTH-1:0]   lowest;
  logic                         found;
  logic [chct_pkg::LEN_W-1:0]   new_len;
  logic [chct_pkg::COUNT_W-1:0] new_left;
  logic                         full;
  logic                         need_len;
  logic [chct_pkg::LEN_W-1:0]   shamt;
  logic [chct_pkg::CODE_W-1:0]  code_use;
  logic [chct_pkg::LEN_W-1:0]   len_use;
  logic                         load_ok;
  logic [chct_pkg::LEN_W-1:0]   idx_m1;

  // Lengths above the current one that still have symbols; the lowest set
  // bit is isolated and encoded with independent OR terms.
  always_comb begin
    for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
      nz[i] = (counts_r[i] != '0) && (chct_pkg::LEN_W'(i + 1) > cur_len_r);
    end
    lowest   = nz & (~nz + MAX_CODE_LENGTH'(1));
    found    = |nz;
    new_len  = '0;
    new_left = '0;
    for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
      new_len  = new_len  | ({chct_pkg::LEN_W{lowest[i]}} & chct_pkg::LEN_W'(i + 1));
      new_left = new_left | ({chct_pkg::COUNT_W{lowest[i]}} & counts_r[i]);
    end
  end

  always_comb begin
    full     = loaded_r >= SL_W'(MAX_SYMBOLS);
    need_len = (left_r == '0);
    shamt    = new_len - cur_len_r;
    code_use = need_len ? chct_pkg::CODE_W'(next_code_r << shamt) : next_code_r;
    len_use  = need_len ? new_len : cur_len_r;
    rsp.ok     = !full && (!need_len || found);
    rsp.code   = code_use;
    rsp.length = len_use;

    next_code_nxt = next_code_r;
    cur_len_nxt   = cur_len_r;
    left_nxt      = left_r;
    loaded_nxt    = loaded_r;
    if (cmd.clear) begin
      next_code_nxt = '0;
      cur_len_nxt   = '0;
      left_nxt      = '0;
      loaded_nxt    = '0;
    end else if (cmd.add && rsp.ok) begin
      next_code_nxt = code_use + chct_pkg::CODE_W'(1);
      cur_len_nxt   = len_use;
      left_nxt      = (need_len ? new_left : left_r) - chct_pkg::COUNT_W'(1);
      loaded_nxt    = loaded_r + SL_W'(1);
    end

    load_ok = cmd.load && (cmd.length_index != '0) &&
              (cmd.length_index <= chct_pkg::LEN_W'(MAX_CODE_LENGTH));
    idx_m1  = cmd.length_index - chct_pkg::LEN_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_code_r <= '0;
      cur_len_r   <= '0;
      left_r      <= '0;
      loaded_r    <= '0;
      for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
        counts_r[i] <= '0;
      end
    end else begin
      next_code_r <= next_code_nxt;
      cur_len_r   <= cur_len_nxt;
      left_r      <= left_nxt;
      loaded_r    <= loaded_nxt;
      if (cmd.clear) begin
        for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
          counts_r[i] <= '0;
        end
      end else if (load_ok) begin
        counts_r[idx_m1[LI_W-1:0]] <= cmd.count;
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.add && rsp.ok) |=> (cur_len_r != '0))
    else $error("append left no code length started");

  assert property (@(posedge clk) disable iff (!rst_n)
    (loaded_r <= SL_W'(MAX_SYMBOLS)))
    else $error("symbol count exceeds limit");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (loaded_r == '0 && left_r == '0 && cur_len_r == '0))
    else $error("new table did not reset the generator");

endmodule
`default_nettype wire

/* rtl/core/canonical_huffman_code_table_unit.sv */
`default_nettype none
// Canonical Huffman code table with symbol lookup.
// Input channel: in_valid/in_stall carry one request word (in_req_type,
// in_length_index, in_count, in_symbol). Output channel: out_valid/out_stall
// carry one result word (out_status, out_code, out_code_length) per request,
// in request order.
// A new table request clears the counts, the generator and the valid bits.
// Load count requests set the symbol count of a code length, add symbol
// requests append symbols and assign the next canonical code.
// New table, load count and add symbol results are registered on acceptance
// and appear in the next cycle; a lookup result passes the registered read
// port of the code store RAM first and then the result register.
// Throughput: one request per cycle while the receiver does not stall, except
// that a lookup holds the input while the code store read completes.
// The result register lets a new request be taken while a result waits; when
// the receiver stalls with a result held, in_stall rises until it is taken.
// Reset (rst_n low, synchronous) empties the table exactly as a new table
// request does; the code store needs no clearing pass since its entries are
// only read behind their valid bits.
module canonical_huffman_code_table_unit #(
  parameter int unsigned MAX_SYMBOLS     = 256,
  parameter int unsigned MAX_CODE_LENGTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [4:0]  in_length_index,
  input  wire logic [7:0]  in_count,
  input  wire logic [7:0]  in_symbol,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [15:0]      out_code,
  output logic [4:0]       out_code_length
);

  chct_pkg::state_t   state_r, state_nxt;
  chct_pkg::req_t     req;
  chct_pkg::gen_cmd_t cmd;
  chct_pkg::gen_rsp_t rsp;

  logic                          accept;
  logic                          out_free;
  logic                          lookup_done;
  logic                          load_out;
  logic [chct_pkg::SYM_COUNT-1:0] valid_map_r, valid_map_nxt;
  logic                          hit_r;
  logic                          ram_we;
  logic [chct_pkg::ENTRY_W-1:0]  ram_rdata;

  logic                          out_valid_r, out_valid_nxt;
  chct_pkg::status_t             out_status_r, out_status_nxt;
  logic [chct_pkg::CODE_W-1:0]   out_code_r, out_code_nxt;
  logic [chct_pkg::LEN_W-1:0]    out_len_r, out_len_nxt;

  assign req      = chct_pkg::req_t'(in_req_type);
  assign out_free = !out_valid_r || !out_stall;
  assign accept   = in_valid && !in_stall;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      chct_pkg::ST_IDLE: begin
        if (accept && req == chct_pkg::REQ_LOOKUP) begin
          state_nxt = chct_pkg::ST_LOOKUP;
        end
      end
      chct_pkg::ST_LOOKUP: begin
        if (out_free) begin
          state_nxt = chct_pkg::ST_IDLE;
        end
      end
      default: state_nxt = chct_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_stall    = 1'b1;
    lookup_done = 1'b0;
    unique case (state_r)
      chct_pkg::ST_IDLE: begin
        in_stall = out_valid_r && out_stall;
      end
      chct_pkg::ST_LOOKUP: begin
        in_stall    = 1'b1;
        lookup_done = out_free;
      end
      default: begin
        in_stall    = 1'b1;
        lookup_done = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd.clear        = accept && req == chct_pkg::REQ_NEW_TABLE;
    cmd.load         = accept && req == chct_pkg::REQ_LOAD_COUNT;
    cmd.add          = accept && req == chct_pkg::REQ_ADD_SYMBOL;
    cmd.length_index = in_length_index;
    cmd.count        = in_count;
  end

  chct_codegen #(
    .MAX_SYMBOLS     (MAX_SYMBOLS),
    .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
  ) u_codegen (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .rsp   (rsp)
  );

  // Only the first append of a symbol writes its entry.
  assign ram_we = cmd.add && rsp.ok && !valid_map_r[in_symbol];

  always_comb begin
    valid_map_nxt = valid_map_r;
    if (cmd.clear) begin
      valid_map_nxt = '0;
    end else if (ram_we) begin
      valid_map_nxt[in_symbol] = 1'b1;
    end
  end

  chct_ram #(
    .WIDTH (chct_pkg::ENTRY_W),
    .DEPTH (chct_pkg::SYM_COUNT)
  ) u_code_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_symbol),
    .wdata ({rsp.length, rsp.code}),
    .re    (accept && req == chct_pkg::REQ_LOOKUP),
    .raddr (in_symbol),
    .rdata (ram_rdata)
  );

  always_comb begin
    load_out       = 1'b0;
    out_status_nxt = out_status_r;
    out_code_nxt   = out_code_r;
    out_len_nxt    = out_len_r;
    if (lookup_done) begin
      load_out = 1'b1;
      if (hit_r) begin
        out_status_nxt = chct_pkg::STATUS_OK;
        out_code_nxt   = ram_rdata[chct_pkg::CODE_W-1:0];
        out_len_nxt    = ram_rdata[chct_pkg::ENTRY_W-1:chct_pkg::CODE_W];
      end else begin
        out_status_nxt = chct_pkg::STATUS_NOT_FOUND;
        out_code_nxt   = '0;
        out_len_nxt    = '0;
      end
    end else if (accept && req != chct_pkg::REQ_LOOKUP) begin
      load_out       = 1'b1;
      out_status_nxt = (cmd.add && !rsp.ok) ? chct_pkg::STATUS_NO_SLOT
                                            : chct_pkg::STATUS_OK;
      out_code_nxt   = '0;
      out_len_nxt    = '0;
    end
    out_valid_nxt = load_out || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= chct_pkg::ST_IDLE;
      valid_map_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_map_r <= valid_map_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_code_r   <= out_code_nxt;
    out_len_r    <= out_len_nxt;
    if (accept && req == chct_pkg::REQ_LOOKUP) begin
      hit_r <= valid_map_r[in_symbol];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_code        = out_code_r;
  assign out_code_length = out_len_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && req == chct_pkg::REQ_LOOKUP) |=> (state_r == chct_pkg::ST_LOOKUP))
    else $error("lookup did not wait for the code store read");

  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !valid_map_r[in_symbol])
    else $error("code store entry overwritten");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (valid_map_r == '0))
    else $error("new table left valid bits set");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == chct_pkg::STATUS_NOT_FOUND) |->
      (out_code_r == '0 && out_len_r == '0))
    else $error("missed lookup returned a nonzero code");

endmodule
`default_nettype wire

/* test/tb_canonical_huffman_code_table_unit.sv */
module tb_canonical_huffman_code_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT    = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 300;
  localparam int PHASE_WORDS  = 256;

  typedef struct {
    chct_pkg::req_t req;
    logic [4:0]     len_idx;
    logic [7:0]     cnt;
    logic [7:0]     sym;
  } req_word_t;

  typedef struct {
    chct_pkg::status_t status;
    logic [15:0]       code;
    logic [4:0]        len;
  } code_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = '0;
  logic [4:0]  in_length_index = '0;
  logic [7:0]  in_count = '0;
  logic [7:0]  in_symbol = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [15:0] out_code;
  logic [4:0]  out_code_length;

  canonical_huffman_code_table_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_length_index (in_length_index),
    .in_count        (in_count),
    .in_symbol       (in_symbol),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_code        (out_code),
    .out_code_length (out_code_length)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Table model: counts per length, the running canonical code and the symbol store.
  logic [7:0]  len_count [16];
  logic [15:0] run_code;
  logic [4:0]  cur_len;
  logic [7:0]  slots_left;
  logic [8:0]  loaded;
  logic [20:0] sym_entry [256];
  bit          sym_known [256];

  req_word_t    words_to_send [$];
  code_result_t results_due [$];
  req_word_t    on_bus;
  int           words_queued = 0;
  int           mismatches = 0;
  int           cycles = 0;
  int           send_idle_pct = 0;
  int           rcv_stall_pct = 0;
  int           hold_requests = 0;
  int           hold_served = 0;
  int           hold_left = 0;

  function automatic void clear_code_table();
    for (int i = 0; i < 16; i++) len_count[i] = '0;
    for (int i = 0; i < chct_pkg::SYM_COUNT; i++) sym_known[i] = 1'b0;
    run_code   = '0;
    cur_len    = '0;
    slots_left = '0;
    loaded     = '0;
  endfunction

  function automatic logic [4:0] next_nonzero_length();
    for (int l = int'(cur_len) + 1; l <= 16; l++) begin
      if (len_count[l-1] != 0) return 5'(l);
    end
    return '0;
  endfunction

  function automatic chct_pkg::status_t append_code(logic [7:0] sym);
    logic [4:0] l;
    if (loaded >= chct_pkg::SYM_COUNT) return chct_pkg::STATUS_NO_SLOT;
    if (slots_left == 0) begin
      l = next_nonzero_length();
      if (l == 0) return chct_pkg::STATUS_NO_SLOT;
      // Moving to a longer length shifts the running code; it wraps at 16 bits.
      run_code   = run_code << (l - cur_len);
      cur_len    = l;
      slots_left = len_count[l-1];
    end
    // A repeated symbol still takes its slot, but the first entry stays.
    if (!sym_known[sym]) begin
      sym_known[sym] = 1'b1;
      sym_entry[sym] = {cur_len, run_code};
    end
    slots_left--;
    run_code++;
    loaded++;
    return chct_pkg::STATUS_OK;
  endfunction

  function automatic code_result_t predict_code_result(req_word_t w);
    code_result_t r;
    r.status = chct_pkg::STATUS_OK;
    r.code   = '0;
    r.len    = '0;
    case (w.req)
      chct_pkg::REQ_NEW_TABLE: clear_code_table();
      chct_pkg::REQ_LOAD_COUNT: begin
        if (w.len_idx >= 1 && w.len_idx <= 16) len_count[w.len_idx - 1] = w.cnt;
      end
      chct_pkg::REQ_ADD_SYMBOL: r.status = append_code(w.sym);
      default: begin
        if (sym_known[w.sym]) begin
          r.code = sym_entry[w.sym][15:0];
          r.len  = sym_entry[w.sym][20:16];
        end else begin
          r.status = chct_pkg::STATUS_NOT_FOUND;
        end
      end
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("%0t ns: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic push_word(chct_pkg::req_t r, int unsigned idx, int unsigned cnt,
                           int unsigned sym);
    req_word_t w;
    w.req     = r;
    w.len_idx = 5'(idx);
    w.cnt     = 8'(cnt);
    w.sym     = 8'(sym);
    words_to_send.push_back(w);
    words_queued++;
  endtask

  task automatic queue_directed();
    push_word(chct_pkg::REQ_LOOKUP, 0, 0, 8'h00);
    push_word(chct_pkg::REQ_ADD_SYMBOL, 0, 0, 8'h55);
    push_word(chct_pkg::REQ_LOAD_COUNT, 0, 8'hFF, 0);
    push_word(chct_pkg::REQ_LOAD_COUNT, 17, 3, 0);
    push_word(chct_pkg::REQ_LOAD_COUNT, 31, 8'hAA, 0);
    push_word(chct_pkg::REQ_LOAD_COUNT, 2, 2, 0);
    push_word(chct_pkg::REQ_LOAD_COUNT, 3, 1, 0);
    push_word(chct_pkg::REQ_LOAD_COUNT, 5, 0, 0);
    push_word(chct_pkg::REQ_LOAD_COUNT, 16, 255, 0);
    push_word(chct_pkg::REQ_ADD_SYMBOL, 0, 0, 8'h00);
    push_word(chct_pkg::REQ_ADD_SYMBOL, 0, 0, 8'hFF);
    push_word(chct_pkg::REQ_ADD_SYMBOL, 0, 0, 8'hFF);
    // Length 3 is already passed, so this count must not matter.
    push_word(chct_pkg::REQ_LOAD_COUNT, 3, 5, 0);
    push_word(chct_pkg::REQ_ADD_SYMBOL, 0, 0, 8'h80);
    push_word(chct_pkg::REQ_LOOKUP, 0, 0, 8'h00);
    push_word(chct_pkg::REQ_LOOKUP, 0, 0, 8'hFF);
    push_word(chct_pkg::REQ_LOOKUP, 0, 0, 8'h80);
    push_word(chct_pkg::REQ_LOOKUP, 0, 0, 8'h7F);
    push_word(chct_pkg::REQ_NEW_TABLE, 0, 0, 0);
    push_word(chct_pkg::REQ_LOOKUP, 0, 0, 8'hFF);
    push_word(chct_pkg::REQ_LOAD_COUNT, 1, 1, 0);
    push_word(chct_pkg::REQ_ADD_SYMBOL, 0, 0, 8'h12);
    push_word(chct_pkg::REQ_ADD_SYMBOL, 0, 0, 8'h34);
    push_word(chct_pkg::REQ_LOOKUP, 0, 0, 8'h12);
    push_word(chct_pkg::REQ_LOOKUP, 0, 0, 8'h34);
  endtask

  // One table: clear (always when full), load counts, append symbols, then look
  // some up. A full table loads more than 256 slots so the symbol limit is reached.
  task automatic queue_random_table(bit full);
    logic [7:0] used [$];
    logic [7:0] s;
    int adds;
    int total;
    int l;
    int c;
    total = 0;
    if (full || $urandom_range(9) != 0)
      push_word(chct_pkg::REQ_NEW_TABLE, $urandom_range(31), $urandom, $urandom);
    if (full) begin
      push_word(chct_pkg::REQ_LOAD_COUNT, $urandom_range(1, 8),
                $urandom_range(200, 255), $urandom);
      push_word(chct_pkg::REQ_LOAD_COUNT, $urandom_range(9, 16),
                $urandom_range(60, 255), $urandom);
      adds = 256 + $urandom_range(2, 6);
    end else begin
      repeat ($urandom_range(1, 4)) begin
        l = ($urandom_range(9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
        c = ($urandom_range(7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
        push_word(chct_pkg::REQ_LOAD_COUNT, l, c, $urandom);
        total += c;
      end
      adds = ((total > 24) ? 24 : total) + $urandom_range(0, 2);
    end
    for (int i = 0; i < adds; i++) begin
      if (!full && $urandom_range(12) == 0)
        push_word(chct_pkg::req_t'($urandom_range(3)), $urandom_range(31), $urandom,
                  $urandom);
      s = (used.size() != 0 && $urandom_range(4) == 0) ?
          used[$urandom_range(used.size() - 1)] : 8'($urandom);
      used.push_back(s);
      push_word(chct_pkg::REQ_ADD_SYMBOL, $urandom_range(31), $urandom, s);
    end
    repeat ($urandom_range(3, 8)) begin
      s = (used.size() != 0 && $urandom_range(9) < 7) ?
          used[$urandom_range(used.size() - 1)] : 8'($urandom);
      push_word(chct_pkg::REQ_LOOKUP, $urandom_range(31), $urandom, s);
    end
  endtask

  task automatic wait_idle();
    while (words_to_send.size() != 0 || in_valid || results_due.size() != 0)
      @(negedge clk);
  endtask

  // Request driver: the payload holds while stalled; unless the driver idles, the
  // next word goes out in the same edge the previous one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) results_due.push_back(predict_code_result(on_bus));
      if (!in_valid || !in_stall) begin
        if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = words_to_send.pop_front();
          in_valid        <= 1'b1;
          in_req_type     <= on_bus.req;
          in_length_index <= on_bus.len_idx;
          in_count        <= on_bus.cnt;
          in_symbol       <= on_bus.sym;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= LONG_HOLD;
      out_stall   <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    code_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        flag_mismatch($sformatf("result word with none expected: status %0d code %0h len %0d",
                                out_status, out_code, out_code_length));
      end else begin
        want = results_due.pop_front();
        if (out_status !== want.status)
          flag_mismatch($sformatf("status got %0d expected %0d", out_status, want.status));
        if (out_code !== want.code)
          flag_mismatch($sformatf("code got %0h expected %0h", out_code, want.code));
        if (out_code_length !== want.len)
          flag_mismatch($sformatf("code length got %0d expected %0d",
                                  out_code_length, want.len));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("FAIL canonical_huffman_code_table_unit");
      $finish;
    end
  end

  initial begin
    int send_pcts [4];
    int rcv_pcts [4];
    int target;
    send_pcts = '{0, 64, 0, 24};
    rcv_pcts  = '{0, 0, 64, 24};
    clear_code_table();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    queue_directed();
    wait_idle();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_pcts[ph];
      rcv_stall_pct = rcv_pcts[ph];
      target = words_queued + PHASE_WORDS;
      queue_random_table(ph == 1 || ph == 3);
      while (words_queued < target) queue_random_table(1'b0);
      // Long receiver hold while the sender keeps offering at full rate.
      if (ph == 0) hold_requests++;
      wait_idle();
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS canonical_huffman_code_table_unit");
    end else begin
      $display("FAIL canonical_huffman_code_table_unit");
    end
    $finish;
  end

endmodule
